// ===== rtl/core/pzip_pkg.sv =====
// POSTNET ZIP encoder package: shared types, constants and digit tables.
// No dependencies; used by pzip_digit_split and postnet_zip_encoder_top.
package pzip_pkg;

    localparam int unsigned ZIP_W   = 17;
    localparam int unsigned CHECK_W = 4;
    localparam int unsigned BAR_W   = 32;
    localparam int unsigned CODE_W  = 5;
    localparam int unsigned SUM_W   = 6;

    localparam logic [ZIP_W-1:0] ZIP_MOD = 17'd100000;

    // ceil(2^27 / 1000): floor(z * RECIP_1000 / 2^27) == z / 1000 for z < 100000
    localparam logic [17:0] RECIP_1000 = 18'd134218;
    localparam int unsigned RECIP_1000_SH = 27;

    // floor(n * 41 / 2^12) == n / 100 for n < 1024
    localparam logic [5:0] RECIP_100 = 6'd41;
    // floor(n * 205 / 2^11) == n / 10 for n < 1029
    localparam logic [7:0] RECIP_10  = 8'd205;

    typedef logic [CHECK_W-1:0] digit_t;

    typedef struct packed {
        digit_t d4;
        digit_t d3;
        digit_t d2;
        digit_t d1;
        digit_t d0;
    } digits_t;

    // 2-of-5 bar code, first bar in the MSB, 1 = full bar
    function automatic logic [CODE_W-1:0] bar_code(input digit_t d);
        logic [CODE_W-1:0] c;
        case (d)
            4'd0:    c = 5'b11000;
            4'd1:    c = 5'b00011;
            4'd2:    c = 5'b00101;
            4'd3:    c = 5'b00110;
            4'd4:    c = 5'b01001;
            4'd5:    c = 5'b01010;
            4'd6:    c = 5'b01100;
            4'd7:    c = 5'b10001;
            4'd8:    c = 5'b10010;
            4'd9:    c = 5'b10100;
            default: c = 5'b11000;
        endcase
        return c;
    endfunction

    // (10 - sum mod 10) mod 10, sum in 0..45
    function automatic digit_t check_of(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] m;
        logic [SUM_W-1:0] c;
        if (sum >= 6'd40)
            m = sum - 6'd40;
        else if (sum >= 6'd30)
            m = sum - 6'd30;
        else if (sum >= 6'd20)
            m = sum - 6'd20;
        else if (sum >= 6'd10)
            m = sum - 6'd10;
        else
            m = sum;
        c = (m == 6'd0) ? 6'd0 : 6'd10 - m;
        return c[CHECK_W-1:0];
    endfunction

endpackage

// ===== rtl/core/pzip_digit_split.sv =====
// Five-stage pipeline: ZIP code mod 100000, then split into five decimal digits.
// Depends on pzip_pkg.
module pzip_digit_split
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pzip_pkg::ZIP_W-1:0]  zip_code,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pzip_pkg::digits_t           digits
);

    localparam int unsigned NSTG = 5;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    // stage A
    logic [pzip_pkg::ZIP_W-1:0] a_z_reg;
    logic [pzip_pkg::ZIP_W-1:0] a_z_next;
    // stage B
    logic [pzip_pkg::ZIP_W-1:0] b_z_reg;
    logic [6:0]                 b_hi_reg;
    logic [6:0]                 b_hi_next;
    logic [34:0]                b_prod;
    // stage C
    pzip_pkg::digit_t           c_d4_reg;
    pzip_pkg::digit_t           c_d3_reg;
    logic [9:0]                 c_lo_reg;
    pzip_pkg::digit_t           c_d4_next;
    pzip_pkg::digit_t           c_d3_next;
    logic [9:0]                 c_lo_next;
    logic [14:0]                c_hi_prod;
    logic [16:0]                c_hi_k;
    logic [16:0]                c_lo_diff;
    logic [6:0]                 c_d3_diff;
    // stage D
    pzip_pkg::digit_t           d_d4_reg;
    pzip_pkg::digit_t           d_d3_reg;
    pzip_pkg::digit_t           d_d2_reg;
    logic [6:0]                 d_r_reg;
    pzip_pkg::digit_t           d_d2_next;
    logic [6:0]                 d_r_next;
    logic [15:0]                d_prod;
    logic [9:0]                 d_r_diff;
    // stage E
    pzip_pkg::digits_t          e_dig_reg;
    pzip_pkg::digits_t          e_dig_next;
    logic [14:0]                e_prod;
    logic [6:0]                 e_d0_diff;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        a_z_next = (zip_code >= pzip_pkg::ZIP_MOD) ? zip_code - pzip_pkg::ZIP_MOD : zip_code;

        b_prod    = 35'(a_z_reg) * 35'(pzip_pkg::RECIP_1000);
        b_hi_next = b_prod[pzip_pkg::RECIP_1000_SH +: 7];

        c_hi_k    = 17'(b_hi_reg) * 17'd1000;
        c_lo_diff = b_z_reg - c_hi_k;
        c_lo_next = c_lo_diff[9:0];
        c_hi_prod = 15'(b_hi_reg) * 15'(pzip_pkg::RECIP_10);
        c_d4_next = c_hi_prod[14:11];
        c_d3_diff = b_hi_reg - 7'(c_d4_next) * 7'd10;
        c_d3_next = c_d3_diff[3:0];

        d_prod    = 16'(c_lo_reg) * 16'(pzip_pkg::RECIP_100);
        d_d2_next = d_prod[15:12];
        d_r_diff  = c_lo_reg - 10'(d_d2_next) * 10'd100;
        d_r_next  = d_r_diff[6:0];

        e_prod        = 15'(d_r_reg) * 15'(pzip_pkg::RECIP_10);
        e_dig_next.d4 = d_d4_reg;
        e_dig_next.d3 = d_d3_reg;
        e_dig_next.d2 = d_d2_reg;
        e_dig_next.d1 = e_prod[14:11];
        e_d0_diff     = d_r_reg - 7'(e_dig_next.d1) * 7'd10;
        e_dig_next.d0 = e_d0_diff[3:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_z_reg <= a_z_next;
        end
        if (adv[1])
        begin
            b_z_reg  <= a_z_reg;
            b_hi_reg <= b_hi_next;
        end
        if (adv[2])
        begin
            c_d4_reg <= c_d4_next;
            c_d3_reg <= c_d3_next;
            c_lo_reg <= c_lo_next;
        end
        if (adv[3])
        begin
            d_d4_reg <= c_d4_reg;
            d_d3_reg <= c_d3_reg;
            d_d2_reg <= d_d2_next;
            d_r_reg  <= d_r_next;
        end
        if (adv[4])
        begin
            e_dig_reg <= e_dig_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTG-1];
    assign digits    = e_dig_reg;

endmodule

// ===== rtl/core/postnet_zip_encoder_top.sv =====
// POSTNET five-digit ZIP encoder, top level: digit split pipeline plus encode stage.
// Depends on pzip_pkg and pzip_digit_split.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------
//  in      | in_valid/in_ready   | zip_code[16:0]
//  out     | out_valid/out_ready | check_digit[3:0], bar_pattern[31:0]
//
// Six register stages: reduce, divide by 1000, split high/low, divide by 100,
// split tens/units, then sum, check digit and bar pattern.
// One request per cycle sustained while out_ready is high.
// Reset clears all valid bits; payload registers are not reset.
// A stall holds the occupied stages up to the first empty one; stages behind it still advance.
module postnet_zip_encoder_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pzip_pkg::ZIP_W-1:0]    zip_code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pzip_pkg::CHECK_W-1:0]  check_digit,
    output logic [pzip_pkg::BAR_W-1:0]    bar_pattern
);

    logic                           spl_valid;
    logic                           spl_ready;
    pzip_pkg::digits_t              spl_digits;

    logic                           f_vld_reg;
    logic                           f_vld_next;
    pzip_pkg::digit_t               f_check_reg;
    pzip_pkg::digit_t               f_check_next;
    logic [pzip_pkg::BAR_W-1:0]     f_pat_reg;
    logic [pzip_pkg::BAR_W-1:0]     f_pat_next;
    logic [pzip_pkg::SUM_W-1:0]     f_sum;

    pzip_digit_split u_split
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .zip_code  (zip_code),
        .out_valid (spl_valid),
        .out_ready (spl_ready),
        .digits    (spl_digits)
    );

    assign spl_ready = !f_vld_reg || out_ready;

    always_comb
    begin
        f_vld_next   = spl_ready ? spl_valid : f_vld_reg;
        f_sum        = 6'(spl_digits.d4) + 6'(spl_digits.d3) + 6'(spl_digits.d2)
                     + 6'(spl_digits.d1) + 6'(spl_digits.d0);
        f_check_next = pzip_pkg::check_of(f_sum);
        f_pat_next   = {1'b1,
                        pzip_pkg::bar_code(spl_digits.d4),
                        pzip_pkg::bar_code(spl_digits.d3),
                        pzip_pkg::bar_code(spl_digits.d2),
                        pzip_pkg::bar_code(spl_digits.d1),
                        pzip_pkg::bar_code(spl_digits.d0),
                        pzip_pkg::bar_code(f_check_next),
                        1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= f_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (spl_ready)
        begin
            f_check_reg <= f_check_next;
            f_pat_reg   <= f_pat_next;
        end
    end

    assign out_valid   = f_vld_reg;
    assign check_digit = f_check_reg;
    assign bar_pattern = f_pat_reg;

    // 2-of-5 per digit over six digits plus two frame bars
    a_bar_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(bar_pattern) == 14))
        else $error("bar pattern does not hold fourteen full bars");

    a_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bar_pattern[31] && bar_pattern[0]))
        else $error("frame bars missing");

    a_check_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (check_digit <= 4'd9))
        else $error("check digit out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (f_vld_reg && !out_ready) |=> (f_vld_reg && $stable(f_pat_reg)))
        else $error("output stage lost a request under stall");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for postnet_zip_encoder_top: random and directed ZIP codes
// against a bar-pattern predictor. Depends on pzip_pkg and the encoder RTL.

module tb;

    class zip_bar_scoreboard;

        typedef struct packed {
            logic [pzip_pkg::CHECK_W-1:0] check_digit;
            logic [pzip_pkg::BAR_W-1:0]   bar_pattern;
            logic [pzip_pkg::ZIP_W-1:0]   zip;
        } bar_result_t;

        bar_result_t expected_q[$];
        int unsigned mismatches;
        int unsigned matched;

        function automatic logic [pzip_pkg::CODE_W-1:0] two_of_five(input int unsigned d);
            case (d)
                0:       return 5'b11000;
                1:       return 5'b00011;
                2:       return 5'b00101;
                3:       return 5'b00110;
                4:       return 5'b01001;
                5:       return 5'b01010;
                6:       return 5'b01100;
                7:       return 5'b10001;
                8:       return 5'b10010;
                default: return 5'b10100;
            endcase
        endfunction

        function void note_zip(input logic [pzip_pkg::ZIP_W-1:0] zip);
            int unsigned value;
            int unsigned dig[5];
            int unsigned sum;
            int unsigned chk;
            bar_result_t r;
            value = int'(zip) % 100000;
            sum = 0;
            for (int i = 0; i < 5; i++)
            begin
                dig[i] = value % 10;
                value  = value / 10;
                sum   += dig[i];
            end
            chk = (10 - sum % 10) % 10;
            r.zip         = zip;
            r.check_digit = chk[pzip_pkg::CHECK_W-1:0];
            r.bar_pattern = {1'b1, two_of_five(dig[4]), two_of_five(dig[3]),
                             two_of_five(dig[2]), two_of_five(dig[1]),
                             two_of_five(dig[0]), two_of_five(chk), 1'b1};
            expected_q.push_back(r);
        endfunction

        function void check_result(input logic [pzip_pkg::CHECK_W-1:0] chk,
                                   input logic [pzip_pkg::BAR_W-1:0] bars);
            bar_result_t r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result check=%0d bars=%h", $realtime, chk, bars);
                return;
            end
            r = expected_q.pop_front();
            if (chk !== r.check_digit || bars !== r.bar_pattern)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: zip %0d: expected check=%0d bars=%h, got check=%0d bars=%h",
                             $realtime, r.zip, r.check_digit, r.bar_pattern, chk, bars);
            end
            else
                matched++;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [pzip_pkg::ZIP_W-1:0]   zip_code;
    logic                         out_valid;
    logic                         out_ready;
    logic [pzip_pkg::CHECK_W-1:0] check_digit;
    logic [pzip_pkg::BAR_W-1:0]   bar_pattern;

    zip_bar_scoreboard sb;
    bit                calm;
    bit                held;
    int unsigned       sent_n;
    int unsigned       over_range_n;
    int unsigned       quiet_cycles;

    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned QUIET_LIMIT  = 5000;
    localparam int unsigned RANDOM_ITEMS = 850;

    postnet_zip_encoder_top i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .zip_code    (zip_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .check_digit (check_digit),
        .bar_pattern (bar_pattern)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_zip(input logic [pzip_pkg::ZIP_W-1:0] zip);
        while (!calm && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        zip_code <= zip;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_zip(zip);
        sent_n++;
        if (zip >= pzip_pkg::ZIP_MOD)
            over_range_n++;
    endtask

    // result side
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(check_digit, bar_pattern);
    end

    // receiver: random stalls, one long hold-off once 300 codes have been sent
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sent_n >= 300)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [pzip_pkg::ZIP_W-1:0] directed[23];
        logic [pzip_pkg::ZIP_W-1:0] zip;
        int unsigned                roll;

        directed = '{
            17'd0, 17'd99999, 17'd100000, 17'd131071, 17'd131070, 17'd12345,
            17'd67890, 17'd55555, 17'd11111, 17'd98765, 17'd100001, 17'd65536,
            17'd99990, 17'd10000, 17'd9, 17'd90, 17'd900, 17'd9000,
            17'd90000, 17'd31071, 17'd45678, 17'd1, 17'd24680
        };
        sb           = new();
        calm         = 1'b0;
        held         = 1'b0;
        sent_n       = 0;
        over_range_n = 0;
        quiet_cycles = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        zip_code <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_zip(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 450 && n < 600);
            roll = $urandom_range(99);
            if (roll < 80)
                zip = 17'($urandom_range(99999));
            else if (roll < 92)
                zip = 17'($urandom_range(131071, 100000));
            else
                zip = 17'($urandom_range(131071));
            send_zip(zip);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d codes (%0d above 99999), %0d results matched, %0d mismatches",
                 sent_n, over_range_n, sb.matched, sb.mismatches);
        $display("covered back-to-back codes, random gaps and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
